[hw/rtl/scan_tone_adjust_and_sharpen_top_assert.svh]
// Assertion macros shared by the tone adjust and sharpen RTL.
`ifndef SCAN_TONE_ADJUST_AND_SHARPEN_TOP_ASSERT_SVH
`define SCAN_TONE_ADJUST_AND_SHARPEN_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define STAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define STAS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define STAS_ASSERT(lbl, prop, msg)
`define STAS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`endif
`endif

[hw/rtl/stas_pkg.sv]
// Package with the constants, types and register codes of the tone adjust and sharpen block.
package stas_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = 16;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned WidthRegW = 13;
  localparam int unsigned ContrastW = 8;
  localparam int unsigned BrightW   = 9;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned OutPadW   = OutDataW - RowW - ColW - LevelW;

  // The level is floor((t + 6553500) / 51400) with t = (2p - 65535) * (100 + c).
  // Adding 256 * 51400 keeps the dividend positive; the bias comes off afterwards.
  localparam int unsigned TermW     = 26;
  localparam int unsigned RecipW    = 27;
  localparam int unsigned QuotW     = 10;
  localparam int unsigned SumW      = 11;
  localparam int unsigned MapDiv    = 51400;
  localparam int unsigned QBias     = 256;
  localparam int unsigned MapOffset = 6553500 + QBias * MapDiv;
  localparam int unsigned MapShift  = 42;
  localparam longint unsigned MapRecip = ((64'd1 << MapShift) + MapDiv - 1) / MapDiv;

  // Sharpening divides a non-negative value below 2**15 by 40.
  localparam int unsigned ShDiv     = 40;
  localparam int unsigned ShShift   = 21;
  localparam int unsigned ShRecip   = ((1 << ShShift) + ShDiv - 1) / ShDiv;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth    = 3'd0,
    CfgHeight   = 3'd1,
    CfgContrast = 3'd2,
    CfgBright   = 3'd3,
    CfgSharpen  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            has_above;
    logic            has_own;
    logic            row_end;
    logic            sharp;
  } stas_tag_t;

  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [LevelW-1:0] above_level;
    logic [LevelW-1:0] own_level;
    logic              has_above;
    logic              has_own;
    logic              row_end;
  } stas_res_t;

endpackage

[hw/rtl/scan_tone_adjust_and_sharpen_top.sv]
// Top level of the scan tone adjust and sharpen block.
//
//   channel   direction  tdata (lowest bit up)                     tlast     tuser
//   s_axis    in         sample[15:0]                              -         -
//   m_axis    out        out_row, out_column, gray_level, 4 zeros  run_last  frame_done
//   cfg       in         index 0..4, data up to 16 bits            -         -
//
// One sample is taken per cycle while s_axis_tready is high. On the last row of a
// frame taller than one row each sample gives two beats, so the single output
// register admits a new sample only as the second beat leaves there.
// Reset sets the registers to their defaults and the position to row 0, column 0.
// A stall at m_axis holds the whole pipeline once the output register is full and the line store stage holds a result.
module scan_tone_adjust_and_sharpen_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stas_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [stas_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [stas_pkg::SampleW-1:0]  s_axis_tdata,   // sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [stas_pkg::OutDataW-1:0] m_axis_tdata,   // out_row, out_column, gray_level
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser    // frame_done
);
  import stas_pkg::*;

  `include "scan_tone_adjust_and_sharpen_top_assert.svh"

  logic [WidthRegW-1:0]        width_q;
  logic [RowW-1:0]             height_q;
  logic signed [ContrastW-1:0] contrast_q;
  logic signed [BrightW-1:0]   bright_q;
  logic                        sharpen_q;

  logic [ColW-1:0]             col_q;
  logic [RowW-1:0]             row_q;

  logic [WidthRegW-1:0]        w_eff;
  logic [RowW-1:0]             h_eff;
  logic                        wrap_col;
  logic [RowW-1:0]             row_pre, pos_row;
  logic [ColW-1:0]             pos_col;
  logic [ColW:0]               col_inc;
  logic [RowW:0]               row_inc;
  logic                        row_end, last_row;
  logic                        in_beat, adv;
  stas_tag_t                   in_tag;

  logic                        tm_valid;
  stas_tag_t                   tm_tag;
  logic [LevelW-1:0]           tm_level;
  logic                        ls_valid;
  stas_res_t                   ls_res;
  logic                        ls_has_res;
  logic                        ob_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WidthRegW'(640);
      height_q   <= RowW'(480);
      contrast_q <= '0;
      bright_q   <= '0;
      sharpen_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgWidth:    width_q    <= cfg_data_i[WidthRegW-1:0];
        CfgHeight:   height_q   <= cfg_data_i[RowW-1:0];
        CfgContrast: contrast_q <= cfg_data_i[ContrastW-1:0];
        CfgBright:   bright_q   <= cfg_data_i[BrightW-1:0];
        CfgSharpen:  sharpen_q  <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = WidthRegW'(1);
    end else if (width_q > WidthRegW'(MaxWidth)) begin
      w_eff = WidthRegW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    h_eff    = (height_q == '0) ? RowW'(1) : height_q;
    wrap_col = ({1'b0, col_q} >= w_eff);
    row_pre  = wrap_col ? row_q + RowW'(1) : row_q;
    pos_row  = (row_pre >= h_eff) ? '0 : row_pre;
    pos_col  = wrap_col ? '0 : col_q;
    col_inc  = {1'b0, pos_col} + (ColW+1)'(1);
    row_inc  = {1'b0, pos_row} + (RowW+1)'(1);
    row_end  = (col_inc == w_eff);
    last_row = (row_inc == {1'b0, h_eff});

    in_tag.row       = pos_row;
    in_tag.col       = pos_col;
    in_tag.has_above = (pos_row != '0);
    in_tag.has_own   = last_row;
    in_tag.row_end   = row_end;
    in_tag.sharp     = sharpen_q && (pos_row >= RowW'(2)) && (pos_col != '0) && !row_end;
  end

  assign ls_has_res    = ls_valid && (ls_res.has_above || ls_res.has_own);
  assign adv           = !ls_has_res || ob_free;
  assign s_axis_tready = adv;
  assign in_beat       = s_axis_tvalid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_beat) begin
      col_q <= row_end ? '0 : col_inc[ColW-1:0];
      if (!row_end) begin
        row_q <= pos_row;
      end else if (last_row) begin
        row_q <= '0;
      end else begin
        row_q <= row_inc[RowW-1:0];
      end
    end
  end

  stas_tone_map u_tone_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .valid_i      (s_axis_tvalid),
    .tag_i        (in_tag),
    .sample_i     (s_axis_tdata),
    .contrast_i   (contrast_q),
    .brightness_i (bright_q),
    .valid_o      (tm_valid),
    .tag_o        (tm_tag),
    .level_o      (tm_level)
  );

  stas_line_store u_line_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (tm_valid),
    .tag_i   (tm_tag),
    .level_i (tm_level),
    .valid_o (ls_valid),
    .res_o   (ls_res)
  );

  stas_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && ls_has_res),
    .res_i   (ls_res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata),
    .last_o  (m_axis_tlast),
    .user_o  (m_axis_tuser),
    .free_o  (ob_free)
  );

  `STAS_ASSERT(a_stall_has_beat, !s_axis_tready |-> m_axis_tvalid, "input stalled with no beat")
  `STAS_ASSERT(a_done_is_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "frame end not last")
  `STAS_ASSERT(a_col_in_range, in_beat |=> (col_q < $past(w_eff)), "column beyond width")
  `STAS_ASSERT_CLK(a_row_in_range, clk_i, rst_ni, in_beat |=> (row_q < $past(h_eff)), "row beyond height")

endmodule

[hw/rtl/stas_tone_map.sv]
// Three-stage pipeline that maps a 16-bit sample to an 8-bit level.
module stas_tone_map (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  stas_pkg::stas_tag_t                    tag_i,
  input  logic [stas_pkg::SampleW-1:0]           sample_i,
  input  logic signed [stas_pkg::ContrastW-1:0]  contrast_i,
  input  logic signed [stas_pkg::BrightW-1:0]    brightness_i,
  output logic                                   valid_o,
  output stas_pkg::stas_tag_t                    tag_o,
  output logic [stas_pkg::LevelW-1:0]            level_o
);
  import stas_pkg::*;

  logic                          s1_valid_q, s2_valid_q, s3_valid_q;
  stas_tag_t                     s1_tag_q, s2_tag_q, s3_tag_q;
  logic [SampleW-1:0]            s1_sample_q;
  logic [TermW-1:0]              s2_term_q;
  logic [QuotW-1:0]              s3_quot_q;

  logic signed [SampleW+1:0]     centred;
  logic signed [ContrastW:0]     gain;
  logic signed [TermW:0]         term_d;
  logic [TermW:0]                norm_sum;
  logic [TermW+RecipW-1:0]       map_prod;
  logic [QuotW-1:0]              quot_d;
  logic signed [SumW-1:0]        lvl_sum;

  always_comb begin
    centred  = $signed({1'b0, s1_sample_q, 1'b0}) - $signed((SampleW+2)'(65535));
    gain     = $signed({contrast_i[ContrastW-1], contrast_i}) + $signed((ContrastW+1)'(100));
    term_d   = centred * gain;
    norm_sum = {s2_term_q[TermW-1], s2_term_q} + (TermW+1)'(MapOffset);
    map_prod = (TermW+RecipW)'(norm_sum[TermW-1:0]) * (TermW+RecipW)'(MapRecip);
    quot_d   = map_prod[MapShift +: QuotW];
    lvl_sum  = $signed({1'b0, s3_quot_q}) - $signed(SumW'(QBias))
             + $signed({{(SumW-BrightW){brightness_i[BrightW-1]}}, brightness_i});
    if (lvl_sum < 0) begin
      level_o = '0;
    end else if (lvl_sum > $signed(SumW'(255))) begin
      level_o = '1;
    end else begin
      level_o = lvl_sum[LevelW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_tag_q    <= tag_i;
      s1_sample_q <= sample_i;
      s2_tag_q    <= s1_tag_q;
      s2_term_q   <= term_d[TermW-1:0];
      s3_tag_q    <= s2_tag_q;
      s3_quot_q   <= quot_d;
    end
  end

  assign valid_o = s3_valid_q;
  assign tag_o   = s3_tag_q;

endmodule

[hw/rtl/stas_line_store.sv]
// Two line stores, neighbour registers and the cross-shaped sharpening stage.
module stas_line_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  stas_pkg::stas_tag_t         tag_i,
  input  logic [stas_pkg::LevelW-1:0] level_i,
  output logic                        valid_o,
  output stas_pkg::stas_res_t         res_o
);
  import stas_pkg::*;

  function automatic logic [LevelW-1:0] sharpen_level(
    input logic [LevelW-1:0] c,
    input logic [LevelW-1:0] l,
    input logic [LevelW-1:0] r,
    input logic [LevelW-1:0] u,
    input logic [LevelW-1:0] d
  );
    logic [LevelW+1:0]  nsum;
    logic signed [15:0] v;
    logic [30:0]        prod;
    logic [9:0]         q;
    nsum = (LevelW+2)'(l) + (LevelW+2)'(r) + (LevelW+2)'(u) + (LevelW+2)'(d);
    v    = $signed(16'd68) * $signed({8'b0, c}) - $signed(16'd7) * $signed({6'b0, nsum});
    prod = 31'(v[14:0]) * 31'(ShRecip);
    q    = prod[ShShift +: 10];
    if (v < 0) begin
      return '0;
    end else if (q > 10'd255) begin
      return '1;
    end else begin
      return q[LevelW-1:0];
    end
  endfunction

  logic [LevelW-1:0] prev_mem  [MaxWidth];
  logic [LevelW-1:0] older_mem [MaxWidth];

  logic              s4_valid_q;
  stas_tag_t         s4_tag_q;
  logic [LevelW-1:0] s4_level_q;
  logic [LevelW-1:0] rd_ctr_q, rd_rgt_q, rd_up_q, left_q;
  logic [ColW-1:0]   col_next;

  assign col_next = tag_i.col + ColW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s4_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_tag_q   <= tag_i;
      s4_level_q <= level_i;
      if (s4_valid_q && (s4_tag_q.col == tag_i.col)) begin
        rd_ctr_q <= s4_level_q;
      end else begin
        rd_ctr_q <= prev_mem[tag_i.col];
      end
      rd_rgt_q <= prev_mem[col_next];
      rd_up_q  <= older_mem[tag_i.col];
      if (s4_valid_q) begin
        prev_mem[s4_tag_q.col]  <= s4_level_q;
        older_mem[s4_tag_q.col] <= rd_ctr_q;
        left_q                  <= rd_ctr_q;
      end
    end
  end

  always_comb begin
    res_o.row       = s4_tag_q.row;
    res_o.col       = s4_tag_q.col;
    res_o.own_level = s4_level_q;
    res_o.has_above = s4_tag_q.has_above;
    res_o.has_own   = s4_tag_q.has_own;
    res_o.row_end   = s4_tag_q.row_end;
    if (s4_tag_q.sharp) begin
      res_o.above_level = sharpen_level(rd_ctr_q, left_q, rd_rgt_q, rd_up_q, s4_level_q);
    end else begin
      res_o.above_level = rd_ctr_q;
    end
  end

  assign valid_o = s4_valid_q;

endmodule

[hw/rtl/stas_out_buf.sv]
// Output register that holds the one or two results of a sample and hands them out in order.
module stas_out_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  stas_pkg::stas_res_t           res_i,
  input  logic                          ready_i,
  output logic                          valid_o,
  output logic [stas_pkg::OutDataW-1:0] data_o,
  output logic                          last_o,
  output logic                          user_o,
  output logic                          free_o
);
  import stas_pkg::*;

  logic              above_q, own_q;
  stas_res_t         res_q;
  logic [RowW-1:0]   row;
  logic [LevelW-1:0] level;

  assign free_o  = (!above_q && !own_q) || (ready_i && (above_q ^ own_q));
  assign valid_o = above_q || own_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= 1'b0;
      own_q   <= 1'b0;
    end else if (load_i) begin
      above_q <= res_i.has_above;
      own_q   <= res_i.has_own;
    end else if (ready_i && above_q) begin
      above_q <= 1'b0;
    end else if (ready_i && own_q) begin
      own_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  always_comb begin
    row    = above_q ? res_q.row - RowW'(1) : res_q.row;
    level  = above_q ? res_q.above_level : res_q.own_level;
    last_o = !(above_q && own_q);
    user_o = !above_q && own_q && res_q.row_end;
    data_o = {OutPadW'(0), level, res_q.col, row};
  end

endmodule
